FILE: hw/rtl/keypad_matrix_scan_debounce_fifo_unit_assert.svh
// Assertion macros used by the keypad scanner ring.
// Both macros expect signals named clk and rst_n in the scope of use.
`ifndef KEYPAD_MATRIX_SCAN_DEBOUNCE_FIFO_UNIT_ASSERT_SVH
`define KEYPAD_MATRIX_SCAN_DEBOUNCE_FIFO_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KMSD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmsd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KMSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmsd assertion failed");

`endif

FILE: hw/rtl/kmsd_pkg.sv
package kmsd_pkg;

  localparam int ROWS       = 9;
  localparam int COLS       = 6;
  localparam int RING_DEPTH = 16;
  localparam int PIN_BITS   = 6;

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH);
  localparam int OFS_W = $clog2(COLS + 1);
  localparam int SUM_W = PTR_W + OFS_W + 1;

  localparam int WAIT_MAX = 15;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam logic ACT_PRESS   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef struct packed {
    logic change;
    logic action;
  } lane_out_t;

  typedef struct packed {
    logic       action;
    logic [2:0] col;
    logic [3:0] row;
  } event_t;

  typedef struct packed {
    logic       event_valid;
    logic [3:0] event_row;
    logic [2:0] event_col;
    logic       event_action;
    logic [3:0] drive_row;
    logic [3:0] events_waiting;
  } result_t;

endpackage

FILE: hw/rtl/kmsd_lane.sv
module kmsd_lane
  import kmsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             sample_en,
  input  logic [ROW_W-1:0] row_sel,
  input  logic             pressed,
  output lane_out_t        lane_out
);

  // One column of the matrix: debounce history and stable state per row.
  logic stable_r [ROWS];
  logic last_r   [ROWS];

  logic change;

  assign change          = (pressed == last_r[row_sel]) && (pressed != stable_r[row_sel]);
  assign lane_out.change = change;
  assign lane_out.action = pressed ? ACT_PRESS : ACT_RELEASE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) begin
        stable_r[r] <= 1'b0;
        last_r[r]   <= 1'b0;
      end
    end else if (sample_en) begin
      last_r[row_sel] <= pressed;
      if (change) begin
        stable_r[row_sel] <= pressed;
      end
    end
  end

endmodule

FILE: hw/rtl/kmsd_ring.sv
`include "keypad_matrix_scan_debounce_fifo_unit_assert.svh"

module kmsd_ring
  import kmsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_en,
  input  lane_out_t [COLS-1:0]  lanes,
  input  logic [ROW_W-1:0]      row_sel,
  input  logic                  pop_en,
  output logic                  pop_hit,
  output event_t                pop_ev,
  output logic [3:0]            waiting
);

  event_t            ring_r [RING_DEPTH];
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [COLS-1:0]   chg;
  logic [COLS-1:0]   acc;
  logic [PTR_W-1:0]  addr [COLS];
  event_t            ev   [COLS];

  for (genvar c = 0; c < COLS; c++) begin : g_ev
    assign chg[c]       = lanes[c].change;
    assign ev[c].action = lanes[c].action;
    assign ev[c].col    = 3'(c);
    assign ev[c].row    = 4'(row_sel);
  end

  // Merge: each changed lane takes the slot after those of lower columns.
  // Lanes whose rank reaches the free space are dropped.
  always_comb begin
    logic [CNT_W-1:0] free;
    logic [OFS_W-1:0] ofs;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] npush;
    free  = CNT_W'(RING_DEPTH - 1) - cnt_r;
    ofs   = '0;
    npush = '0;
    for (int c = 0; c < COLS; c++) begin
      acc[c] = push_en && chg[c] && (32'(ofs) < 32'(free));
      sum    = SUM_W'(tail_r) + SUM_W'(ofs);
      if (sum >= SUM_W'(RING_DEPTH)) begin
        sum = sum - SUM_W'(RING_DEPTH);
      end
      addr[c] = PTR_W'(sum);
      if (acc[c]) begin
        npush = npush + 1'b1;
      end
      ofs = ofs + OFS_W'(chg[c]);
    end

    sum = SUM_W'(tail_r) + SUM_W'(npush);
    if (sum >= SUM_W'(RING_DEPTH)) begin
      sum = sum - SUM_W'(RING_DEPTH);
    end
    tail_nxt = PTR_W'(sum);

    pop_hit  = pop_en && (cnt_r != '0);
    head_nxt = head_r;
    if (pop_hit) begin
      head_nxt = (head_r == PTR_W'(RING_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end

    cnt_nxt = cnt_r + npush;
    if (pop_hit) begin
      cnt_nxt = cnt_r - 1'b1;
    end

    waiting = (32'(cnt_nxt) > WAIT_MAX) ? 4'(WAIT_MAX) : 4'(cnt_nxt);
  end

  assign pop_ev = ring_r[head_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      for (int c = 0; c < COLS; c++) begin
        if (acc[c] && (addr[c] == PTR_W'(i))) begin
          ring_r[i] <= ev[c];
        end
      end
    end
  end

  `KMSD_ASSERT_NEXT(a_pop_dec, pop_en && (cnt_r != '0), cnt_r == $past(cnt_r) - 1'b1)
  `KMSD_ASSERT_NEXT(a_quiet_hold, push_en && (chg == '0), $stable(cnt_r))
  `KMSD_ASSERT_SAME(a_ptr_cnt, 1'b1, (tail_r >= head_r) ? (32'(tail_r) - 32'(head_r) == 32'(cnt_r)) : (32'(tail_r) + RING_DEPTH - 32'(head_r) == 32'(cnt_r)))

endmodule

FILE: hw/rtl/kmsd_obuf.sv
module kmsd_obuf
  import kmsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  // Two-entry result buffer; slot 0 is the one shown on the port.
  result_t    slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  logic       wpos;

  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot_r[0];
  assign pop       = out_valid && !out_stall;
  assign wpos      = (cnt_r == 2'd2) || ((cnt_r == 2'd1) && !pop);

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // A new result lands in slot 0 when that slot is free after this edge;
  // otherwise, on a pop, slot 0 takes over whatever slot 1 held.
  always_ff @(posedge clk) begin
    if (push && !wpos) begin
      slot_r[0] <= push_data;
    end else if (pop) begin
      slot_r[0] <= slot_r[1];
    end
    if (push && wpos) begin
      slot_r[1] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/keypad_matrix_scan_debounce_fifo_unit.sv
// Channel  | Direction | Handshake         | Payload
// in_      | input     | in_valid/in_stall | in_opcode, in_col_levels
// out_     | output    | out_valid/out_stall | out_event_*, out_drive_row, out_events_waiting
//
// Lanes, ring and row counter update at the edge that accepts an item; one item can
// be accepted in every cycle in which in_stall is low. Each result is registered in
// the result buffer and offered on out_ once the results before it have left.
// rst_n is synchronous and active low; it clears the debounce state, ring pointers,
// row counter and the result buffer.
// A two-entry result buffer absorbs output stalls; in_stall is high only while
// both of its entries are held.
module keypad_matrix_scan_debounce_fifo_unit
  import kmsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_opcode,
  input  logic [5:0] in_col_levels,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_event_valid,
  output logic [3:0] out_event_row,
  output logic [2:0] out_event_col,
  output logic       out_event_action,
  output logic [3:0] out_drive_row,
  output logic [3:0] out_events_waiting
);

  logic                 accept;
  logic                 sample_en;
  logic                 pop_en;
  logic                 buf_full;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [COLS-1:0]      pressed;
  lane_out_t [COLS-1:0] lanes;
  logic                 pop_hit;
  event_t               pop_ev;
  logic [3:0]           waiting;
  result_t              res;
  result_t              out_res;

  // A transfer on the input side happens whenever in_valid is high and the buffer has room.
  assign in_stall  = buf_full;
  assign accept    = in_valid && !in_stall;
  assign sample_en = accept && (in_opcode == OP_SAMPLE);
  assign pop_en    = accept && (in_opcode == OP_POP);

  // Column pins are active low. Columns beyond the pin field always read released.
  for (genvar c = 0; c < COLS; c++) begin : g_lane
    if (c < PIN_BITS) begin : g_pin
      assign pressed[c] = ~in_col_levels[c];
    end else begin : g_nopin
      assign pressed[c] = 1'b0;
    end

    kmsd_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .sample_en (sample_en),
      .row_sel   (row_r),
      .pressed   (pressed[c]),
      .lane_out  (lanes[c])
    );
  end

  // The ring merges the lane events in column order and serves pops.
  kmsd_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_en (sample_en),
    .lanes   (lanes),
    .row_sel (row_r),
    .pop_en  (pop_en),
    .pop_hit (pop_hit),
    .pop_ev  (pop_ev),
    .waiting (waiting)
  );

  // The row counter steps only on samples and wraps after the last row.
  always_comb begin
    row_nxt = row_r;
    if (sample_en) begin
      row_nxt = (row_r == ROW_W'(ROWS - 1)) ? '0 : row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  // Event fields read as zero unless a pop found an event.
  always_comb begin
    res.event_valid    = pop_hit;
    res.event_row      = pop_hit ? pop_ev.row : 4'd0;
    res.event_col      = pop_hit ? pop_ev.col : 3'd0;
    res.event_action   = pop_hit ? pop_ev.action : 1'b0;
    res.drive_row      = 4'(row_nxt);
    res.events_waiting = waiting;
  end

  kmsd_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_event_valid    = out_res.event_valid;
  assign out_event_row      = out_res.event_row;
  assign out_event_col      = out_res.event_col;
  assign out_event_action   = out_res.event_action;
  assign out_drive_row      = out_res.drive_row;
  assign out_events_waiting = out_res.events_waiting;

endmodule

FILE: dv/keypad_event_checker.sv
module keypad_event_checker
  import kmsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_opcode,
  input  logic [5:0]  in_col_levels,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_event_valid,
  input  logic [3:0]  out_event_row,
  input  logic [2:0]  out_event_col,
  input  logic        out_event_action,
  input  logic [3:0]  out_drive_row,
  input  logic [3:0]  out_events_waiting,
  output int unsigned fail_count,
  output int unsigned results_due,
  output int unsigned events_popped,
  output int unsigned events_dropped
);

  // Shadow copy of the debounce lanes, event ring and row counter.
  logic [COLS-1:0]  key_state [ROWS];
  logic [COLS-1:0]  prev_read [ROWS];
  event_t           ring_mem  [RING_DEPTH];
  logic [PTR_W-1:0] ring_rd;
  logic [PTR_W-1:0] ring_wr;
  logic [ROW_W-1:0] scan_row;

  result_t     keypad_results_due[$];
  result_t     want_res;
  int unsigned errs;
  int unsigned popped;
  int unsigned dropped;

  function automatic result_t next_keypad_result(input logic op, input logic [5:0] levels);
    result_t          res;
    event_t           ev;
    logic             pressed;
    logic [PTR_W-1:0] nxt;
    logic [PTR_W-1:0] held;
    int               r;
    int               c;
    res = '0;
    if (op == OP_SAMPLE) begin
      r = int'(scan_row);
      for (c = 0; c < COLS; c++) begin
        // Pins beyond the sampled field float high, so those keys read released.
        pressed = (c < PIN_BITS) ? ~levels[c] : 1'b0;
        if (pressed == prev_read[r][c] && pressed != key_state[r][c]) begin
          key_state[r][c] = pressed;
          ev.action = pressed ? ACT_PRESS : ACT_RELEASE;
          ev.col    = 3'(c);
          ev.row    = 4'(r);
          nxt = ring_wr + 1'b1;
          if (nxt != ring_rd) begin
            ring_mem[ring_wr] = ev;
            ring_wr = nxt;
          end else begin
            dropped++;
          end
        end
        prev_read[r][c] = pressed;
      end
      scan_row = (r == ROWS - 1) ? '0 : ROW_W'(r + 1);
    end else if (ring_rd != ring_wr) begin
      ev = ring_mem[ring_rd];
      res.event_valid  = 1'b1;
      res.event_row    = ev.row;
      res.event_col    = ev.col;
      res.event_action = ev.action;
      ring_rd = ring_rd + 1'b1;
      popped++;
    end
    held = ring_wr - ring_rd;
    res.drive_row      = 4'(scan_row);
    res.events_waiting = (int'(held) > WAIT_MAX) ? 4'(WAIT_MAX) : 4'(held);
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) begin
        key_state[r] = '0;
        prev_read[r] = '0;
      end
      ring_rd  = '0;
      ring_wr  = '0;
      scan_row = '0;
      keypad_results_due.delete();
    end else begin
      // A result leaving at this edge belongs to an item accepted earlier,
      // so it is matched before this edge's input is predicted.
      if (out_valid && !out_stall) begin
        if (keypad_results_due.size() == 0) begin
          $error("result transfer with no result expected");
          errs++;
        end else begin
          want_res = keypad_results_due.pop_front();
          check_field("event_valid", want_res.event_valid, out_event_valid);
          check_field("event_row", want_res.event_row, out_event_row);
          check_field("event_col", want_res.event_col, out_event_col);
          check_field("event_action", want_res.event_action, out_event_action);
          check_field("drive_row", want_res.drive_row, out_drive_row);
          check_field("events_waiting", want_res.events_waiting, out_events_waiting);
        end
      end
      if (in_valid && !in_stall)
        keypad_results_due.push_back(next_keypad_result(in_opcode, in_col_levels));
    end
    fail_count     <= errs;
    results_due    <= keypad_results_due.size();
    events_popped  <= popped;
    events_dropped <= dropped;
  end

endmodule

FILE: dv/tb_top.sv
module tb_top
  import kmsd_pkg::*;
();

  // A run with no transfer on either channel for this many cycles is hung.
  localparam int unsigned HANG_LIMIT   = 1000;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned BLOCK_ITEMS  = 45;
  // From this item on neither side idles, so the tail runs at full rate.
  localparam int unsigned DRAIN_FROM   = 360;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_opcode;
  logic [5:0] in_col_levels;
  logic       out_valid;
  logic       out_stall;
  logic       out_event_valid;
  logic [3:0] out_event_row;
  logic [2:0] out_event_col;
  logic       out_event_action;
  logic [3:0] out_drive_row;
  logic [3:0] out_events_waiting;

  int unsigned fail_count;
  int unsigned results_due;
  int unsigned events_popped;
  int unsigned events_dropped;

  // Stimulus bookkeeping: the row the block will scan next and the key
  // pattern held down on each row, as raw active-low pin levels.
  logic [5:0]  key_img [ROWS];
  int unsigned stim_row;
  int unsigned scans_sent;
  int unsigned pops_sent;
  int unsigned quiet_cycles;
  bit          drain_phase;

  keypad_matrix_scan_debounce_fifo_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_col_levels      (in_col_levels),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_valid    (out_event_valid),
    .out_event_row      (out_event_row),
    .out_event_col      (out_event_col),
    .out_event_action   (out_event_action),
    .out_drive_row      (out_drive_row),
    .out_events_waiting (out_events_waiting)
  );

  keypad_event_checker u_event_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_col_levels      (in_col_levels),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_valid    (out_event_valid),
    .out_event_row      (out_event_row),
    .out_event_col      (out_event_col),
    .out_event_action   (out_event_action),
    .out_drive_row      (out_drive_row),
    .out_events_waiting (out_events_waiting),
    .fail_count         (fail_count),
    .results_due        (results_due),
    .events_popped      (events_popped),
    .events_dropped     (events_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Presents one item and holds it until the block takes it. Before the item
  // the input side may go idle for a random burst. The valid is only lowered
  // when a gap follows, so it never toggles twice in one step.
  task automatic send_item(input logic op, input logic [5:0] levels);
    int unsigned gap;
    gap = 0;
    if (!drain_phase && $urandom_range(0, 2) == 0)
      gap = $urandom_range(1, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_col_levels <= levels;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_SAMPLE) begin
      stim_row = (stim_row == ROWS - 1) ? 0 : stim_row + 1;
      scans_sent++;
    end else begin
      pops_sent++;
    end
  endtask

  // Reads the pattern held on the row being scanned. Now and then a contact
  // bounces for one read, which the two-read debounce should filter out.
  task automatic send_scan();
    logic [5:0] levels;
    levels = key_img[stim_row];
    if ($urandom_range(0, 7) == 0)
      levels = levels ^ (6'b1 << $urandom_range(0, 5));
    send_item(OP_SAMPLE, levels);
  endtask

  // Occasionally the user changes what is held: a single key goes down or up,
  // or a whole row is pressed or let go at once.
  task automatic move_fingers();
    int unsigned r;
    r = $urandom_range(0, ROWS - 1);
    if ($urandom_range(0, 7) == 0)
      key_img[r] = $urandom_range(0, 1) ? 6'h3F : 6'h00;
    else
      key_img[r] = key_img[r] ^ (6'b1 << $urandom_range(0, 5));
  endtask

  initial begin
    int unsigned mode;
    int unsigned pop_odds;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_opcode     <= OP_SAMPLE;
    in_col_levels <= 6'h3F;
    drain_phase   = 1'b0;
    stim_row      = 0;
    scans_sent    = 0;
    pops_sent     = 0;
    mode          = 0;
    pop_odds      = 4;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. A pop straight after reset finds the ring empty. Two
    // full scans with every pin low then press all keys of all rows, far
    // more events than the ring holds, so the tail of them is dropped.
    // A few pops then return the oldest events in row and column order.
    send_item(OP_POP, 6'h3F);
    repeat (2 * ROWS) send_item(OP_SAMPLE, 6'h00);
    repeat (3) send_item(OP_POP, 6'h00);
    for (int r = 0; r < ROWS; r++)
      key_img[r] = 6'h00;

    // Random part, in blocks with a character of their own. Pop-light blocks
    // drive the ring into overflow, pop-heavy ones drain it and pop it empty,
    // and noise blocks throw arbitrary opcodes and pin levels at the block.
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % BLOCK_ITEMS == 0) begin
        mode     = $urandom_range(0, 7);
        pop_odds = (mode <= 2) ? 10 : (mode <= 5) ? 4 : 2;
      end
      if (n == DRAIN_FROM)
        drain_phase = 1'b1;
      if (mode == 0) begin
        send_item(1'($urandom_range(0, 1)), 6'($urandom));
      end else if ($urandom_range(1, pop_odds) == 1) begin
        send_item(OP_POP, 6'($urandom));
      end else begin
        if ($urandom_range(0, 5) == 0)
          move_fingers();
        send_scan();
      end
    end
    in_valid <= 1'b0;

    // Wait for every predicted result, then go on clocking so that any
    // stray result transfer would still be caught.
    do @(posedge clk); while (results_due != 0);
    repeat (4) @(posedge clk);

    $display("Run covered %0d scan and %0d pop transfers, with bounce, overflow and empty pops.",
             scans_sent, pops_sent);
    $display("The ring returned %0d key events and dropped %0d while full.",
             events_popped, events_dropped);
    if (fail_count == 0) begin
      $display("** keypad_matrix_scan_debounce_fifo_unit: PASSED **");
    end else begin
      $display("** keypad_matrix_scan_debounce_fifo_unit: FAILED **");
    end
    $finish;
  end

  // The result side stalls in random bursts between free-running stretches,
  // and stops stalling once the run enters its final stretch.
  initial begin
    forever begin
      if (drain_phase) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Hang detection: counts cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $error("no transfer for %0d cycles, %0d results still due", HANG_LIMIT, results_due);
        $display("** keypad_matrix_scan_debounce_fifo_unit: FAILED **");
        $finish;
      end
    end
  end

endmodule

FILE: keypad_matrix_scan_debounce_fifo_unit.f
+incdir+hw/rtl
hw/rtl/kmsd_pkg.sv
hw/rtl/kmsd_lane.sv
hw/rtl/kmsd_ring.sv
hw/rtl/kmsd_obuf.sv
hw/rtl/keypad_matrix_scan_debounce_fifo_unit.sv
dv/keypad_event_checker.sv
dv/tb_top.sv
